### design/psd_pkg.sv
// Shared widths, region codes and the pipeline tag type for the point-to-segment distance block.
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;
  localparam int COORD_W = 16;               // input coordinate width
  localparam int FRAC_W  = 8;                // fraction bits of the distance
  localparam int DIFF_W  = COORD_W + 1;      // coordinate differences
  localparam int PROD_W  = 2 * DIFF_W;       // products of differences
  localparam int SUM_W   = PROD_W + 1;       // dot and cross products
  localparam int MAG_W   = PROD_W;           // magnitudes and squared lengths
  localparam int DEN_W   = MAG_W;            // divisor width
  localparam int REM_W   = DEN_W + 1;        // partial remainder width
  localparam int NUM_W   = 2 * MAG_W + 2 * FRAC_W;  // scaled numerator
  localparam int QUO_W   = 51;               // quotient bits kept (value below 2^49)
  localparam int ROOT_W  = 25;               // result width
  localparam int OUT_DATA_W = 32;
  localparam int IN_DATA_W  = 6 * COORD_W;

  typedef logic [1:0] region_t;
  localparam region_t REG_INTERIOR = 2'd0;
  localparam region_t REG_START    = 2'd1;
  localparam region_t REG_END      = 2'd2;

  // Control that travels beside each request through the pipeline.
  typedef struct packed {
    logic    vld;
    region_t region;
  } psd_tag_t;
endpackage
`default_nettype wire

### design/psd_div.sv
// Fully pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psd_div import psd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire psd_tag_t         in_tag,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  output psd_tag_t              out_tag,
  output logic [QUO_W-1:0]      out_quo
);
  logic [REM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [QUO_W-1:0] num_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  psd_tag_t         tag_r [QUO_W];

  genvar k;
  generate
    for (k = 0; k < QUO_W; k++) begin : g_stage
      logic [REM_W-1:0] prem;
      logic [QUO_W-1:0] pquo;
      logic [QUO_W-1:0] pnum;
      logic [DEN_W-1:0] pden;
      psd_tag_t         ptag;
      logic [REM_W-1:0] trial;
      logic             ge;

      // Previous stage, or the request itself for the first stage.
      if (k == 0) begin : g_first
        assign prem = REM_W'(in_num[NUM_W-1:QUO_W]);
        assign pquo = '0;
        assign pnum = in_num[QUO_W-1:0];
        assign pden = in_den;
        assign ptag = in_tag;
      end else begin : g_next
        assign prem = rem_r[k-1];
        assign pquo = quo_r[k-1];
        assign pnum = num_r[k-1];
        assign pden = den_r[k-1];
        assign ptag = tag_r[k-1];
      end

      // Bring down the next numerator bit and try one subtraction.
      assign trial = {prem[REM_W-2:0], pnum[QUO_W-1-k]};
      assign ge    = (trial >= REM_W'(pden));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[k] <= '0;
        end else if (en) begin
          tag_r[k] <= ptag;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (trial - REM_W'(pden)) : trial;
          quo_r[k] <= {pquo[QUO_W-2:0], ge};
          num_r[k] <= pnum;
          den_r[k] <= pden;
        end
      end
    end
  endgenerate

  assign out_tag = tag_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];
endmodule
`default_nettype wire

### design/psd_sqrt.sv
// Fully pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt import psd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire psd_tag_t          in_tag,
  input  wire logic [QUO_W-1:0]  in_val,
  output psd_tag_t               out_tag,
  output logic [ROOT_W-1:0]      out_root
);
  logic [QUO_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  psd_tag_t          tag_r  [ROOT_W];

  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [QUO_W-1:0]  prem;
      logic [ROOT_W-1:0] proot;
      psd_tag_t          ptag;
      logic [QUO_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
        assign prem  = in_val;
        assign proot = '0;
        assign ptag  = in_tag;
      end else begin : g_next
        assign prem  = rem_r[k-1];
        assign proot = root_r[k-1];
        assign ptag  = tag_r[k-1];
      end

      // Setting root bit B adds 2*root*2^B + 2^(2B) to the square.
      assign trial = (QUO_W'(proot) << (B + 1)) | (QUO_W'(1) << (2 * B));
      assign ge    = (prem >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[k] <= '0;
        end else if (en) begin
          tag_r[k] <= ptag;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? (prem - trial) : prem;
          root_r[k] <= ge ? (proot | (ROOT_W'(1) << B)) : proot;
        end
      end
    end
  endgenerate

  assign out_tag  = tag_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
endmodule
`default_nettype wire

### design/point_segment_distance.sv
// Top level of the point-to-segment distance pipeline.
// Each request carries a point P and segment endpoints A and B; the result is the distance from
// P to segment AB, floored, with 8 fraction bits, plus the nearest region (0 interior, 1 start,
// 2 end). The block takes one request every cycle unless stalled and returns results in request
// order through 5 stages of geometry (differences, products, sums, region choice, squaring), 51
// stages of the bit-per-stage divider and 25 stages of the bit-per-stage square root. The whole
// pipeline advances together and holds while a finished result waits on out_tready.
`timescale 1ns / 1ps
`default_nettype none
module point_segment_distance import psd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // point_x[15:0], point_y[31:16], start_x[47:32], start_y[63:48], end_x[79:64], end_y[95:80]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // distance_q8[24:0], zeros above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // nearest_region[1:0]
  output logic [1:0]                 out_tuser
);
  logic en;

  // Stage 1: differences.
  logic signed [DIFF_W-1:0] wx_r, wy_r, ex_r, ey_r, vx_r, vy_r;
  logic                     v1_r;
  // Stage 2: products.
  logic signed [PROD_W-1:0] pwe_x_r, pwe_y_r, pee_x_r, pee_y_r, pc1_r, pc2_r;
  logic signed [PROD_W-1:0] pww_x_r, pww_y_r, pvv_x_r, pvv_y_r;
  logic                     v2_r;
  // Stage 3: sums.
  logic signed [SUM_W-1:0]  dot_r, cross_r;
  logic [MAG_W-1:0]         len2_r, w2_r, v2sq_r;
  logic                     v3_r;
  // Stage 4: region choice.
  region_t                  reg4_r;
  logic [MAG_W-1:0]         crmag_r, len24_r, dist4_r;
  logic                     v4_r;
  // Stage 5: divider operands.
  logic [NUM_W-1:0]         num_r;
  logic [DEN_W-1:0]         den_r;
  psd_tag_t                 tag5_r;

  psd_tag_t                 div_tag, sq_tag;
  logic [QUO_W-1:0]         div_quo;
  logic [ROOT_W-1:0]        root;

  logic signed [SUM_W-1:0]  cross_abs;
  logic signed [SUM_W-1:0]  len2_s;
  region_t                  reg_nxt;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Valid bits of the geometry stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      tag5_r <= '0;
    end else if (en) begin
      v1_r   <= in_tvalid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      tag5_r <= '{vld: v4_r, region: reg4_r};
    end
  end

  // Region rule: degenerate or behind A goes to A, past B goes to B.
  assign len2_s    = SUM_W'(len2_r);
  assign cross_abs = cross_r[SUM_W-1] ? -cross_r : cross_r;
  always_comb begin
    if (len2_r == '0 || dot_r <= 0) begin
      reg_nxt = REG_START;
    end else if (dot_r >= len2_s) begin
      reg_nxt = REG_END;
    end else begin
      reg_nxt = REG_INTERIOR;
    end
  end

  // Geometry datapath.
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= DIFF_W'(signed'(in_tdata[15:0]))  - DIFF_W'(signed'(in_tdata[47:32]));
      wy_r <= DIFF_W'(signed'(in_tdata[31:16])) - DIFF_W'(signed'(in_tdata[63:48]));
      ex_r <= DIFF_W'(signed'(in_tdata[79:64])) - DIFF_W'(signed'(in_tdata[47:32]));
      ey_r <= DIFF_W'(signed'(in_tdata[95:80])) - DIFF_W'(signed'(in_tdata[63:48]));
      vx_r <= DIFF_W'(signed'(in_tdata[15:0]))  - DIFF_W'(signed'(in_tdata[79:64]));
      vy_r <= DIFF_W'(signed'(in_tdata[31:16])) - DIFF_W'(signed'(in_tdata[95:80]));

      pwe_x_r <= PROD_W'(wx_r) * PROD_W'(ex_r);
      pwe_y_r <= PROD_W'(wy_r) * PROD_W'(ey_r);
      pee_x_r <= PROD_W'(ex_r) * PROD_W'(ex_r);
      pee_y_r <= PROD_W'(ey_r) * PROD_W'(ey_r);
      pc1_r   <= PROD_W'(wx_r) * PROD_W'(ey_r);
      pc2_r   <= PROD_W'(wy_r) * PROD_W'(ex_r);
      pww_x_r <= PROD_W'(wx_r) * PROD_W'(wx_r);
      pww_y_r <= PROD_W'(wy_r) * PROD_W'(wy_r);
      pvv_x_r <= PROD_W'(vx_r) * PROD_W'(vx_r);
      pvv_y_r <= PROD_W'(vy_r) * PROD_W'(vy_r);

      dot_r   <= SUM_W'(pwe_x_r) + SUM_W'(pwe_y_r);
      cross_r <= SUM_W'(pc1_r) - SUM_W'(pc2_r);
      len2_r  <= MAG_W'(SUM_W'(pee_x_r) + SUM_W'(pee_y_r));
      w2_r    <= MAG_W'(SUM_W'(pww_x_r) + SUM_W'(pww_y_r));
      v2sq_r  <= MAG_W'(SUM_W'(pvv_x_r) + SUM_W'(pvv_y_r));

      reg4_r  <= reg_nxt;
      crmag_r <= MAG_W'(cross_abs);
      len24_r <= len2_r;
      dist4_r <= (reg_nxt == REG_END) ? v2sq_r : w2_r;

      // Endpoint cases divide by one so every request takes the same path.
      if (reg4_r == REG_INTERIOR) begin
        num_r <= (NUM_W'(crmag_r) * NUM_W'(crmag_r)) << (2 * FRAC_W);
        den_r <= len24_r;
      end else begin
        num_r <= NUM_W'(dist4_r) << (2 * FRAC_W);
        den_r <= DEN_W'(1);
      end
    end
  end

  psd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (tag5_r),
    .in_num  (num_r),
    .in_den  (den_r),
    .out_tag (div_tag),
    .out_quo (div_quo)
  );

  psd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (div_tag),
    .in_val   (div_quo),
    .out_tag  (sq_tag),
    .out_root (root)
  );

  assign out_tvalid = sq_tag.vld;
  assign out_tdata  = OUT_DATA_W'(root);
  assign out_tuser  = sq_tag.region;

  // A request accepted now enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted request did not enter the pipeline");

  // The pipeline advances only when the result register is free or being taken.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("pipeline advance does not follow the result handshake");

  // A chosen region is always one of the three meaningful codes.
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (reg4_r == REG_INTERIOR || reg4_r == REG_START || reg4_r == REG_END))
    else $error("bad region code");

  // Endpoint requests always divide by one.
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    tag5_r.vld && tag5_r.region != REG_INTERIOR |-> den_r == DEN_W'(1))
    else $error("endpoint request with nonunit divisor");
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the point-to-segment distance pipeline.
`timescale 1ns / 1ps
module testbench;
  import psd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  typedef struct {
    logic signed [15:0] px, py, ax, ay, bx, by;
  } query_t;

  typedef struct {
    logic [24:0] dist_q8;
    region_t     region;
  } answer_t;

  // Directed row: a query plus an optional hand-worked answer.
  typedef struct {
    query_t  q;
    logic    known;
    answer_t ans;
  } row_t;

  answer_t pending_answers[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int region_hits[3] = '{0, 0, 0};

  point_segment_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // Largest r with r*r <= m.
  function automatic logic [63:0] isqrt(logic [127:0] m);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= m) r = c;
    end
    return r;
  endfunction

  // Distance to the closed segment in Q.8, floored, and which part is nearest.
  function automatic answer_t segment_distance(query_t q);
    logic signed [63:0] wx, wy, ex, ey, vx, vy, dotp, cr;
    logic [63:0] len2, d2;
    logic [127:0] m;
    answer_t a;
    wx = q.px - q.ax; wy = q.py - q.ay;
    ex = q.bx - q.ax; ey = q.by - q.ay;
    vx = q.px - q.bx; vy = q.py - q.by;
    dotp = wx * ex + wy * ey;
    len2 = ex * ex + ey * ey;
    if (len2 == 0 || dotp <= 0) begin
      d2 = wx * wx + wy * wy;
      a.region = REG_START;
      m = {64'd0, d2} << 16;
    end else if (dotp >= $signed(len2)) begin
      d2 = vx * vx + vy * vy;
      a.region = REG_END;
      m = {64'd0, d2} << 16;
    end else begin
      cr = wx * ey - wy * ex;
      if (cr < 0) cr = -cr;
      // floor(cr^2 * 2^16 / len2); floor of sqrt is unaffected by flooring the quotient.
      m = (({64'd0, cr} * {64'd0, cr}) << 16) / {64'd0, len2};
      a.region = REG_INTERIOR;
    end
    a.dist_q8 = 25'(isqrt(m));
    return a;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
  endfunction

  // Drive one request and wait for its acceptance; valid stays up for a back-to-back request.
  task automatic send_query(query_t q, logic known, answer_t ans);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata <= {q.by, q.bx, q.ay, q.ax, q.py, q.px};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (known) pending_answers.push_back(ans);
    else pending_answers.push_back(segment_distance(q));
    sent++;
  endtask

  // Receiver with random stalls and a checker on every accepted result.
  initial begin
    answer_t e;
    int hold;
    int g;
    hold = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        received++;
        if (pending_answers.size() == 0) begin
          $error("unexpected result: distance_q8=%0d", out_tdata[24:0]);
          errors++;
        end else begin
          e = pending_answers.pop_front();
          region_hits[e.region]++;
          if (out_tdata[24:0] !== e.dist_q8) begin
            $error("distance_q8 expected %0d actual %0d", e.dist_q8, out_tdata[24:0]);
            errors++;
          end
          if (out_tdata[31:25] !== 7'd0) begin
            $error("tdata pad expected 0 actual %0h", out_tdata[31:25]);
            errors++;
          end
          if (out_tuser !== e.region) begin
            $error("nearest_region expected %0d actual %0d", e.region, out_tuser);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          hold = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    query_t q;
    answer_t none;
    int span;
    none = '{dist_q8: '0, region: REG_INTERIOR};

    // Directed rows: degenerate, both endpoints, interior, extremes.
    r = '{q: '{3, 4, 0, 0, 0, 0}, known: 1, ans: '{1280, REG_START}}; rows.push_back(r);
    r = '{q: '{0, 0, 0, 0, 0, 0}, known: 1, ans: '{0, REG_START}}; rows.push_back(r);
    r = '{q: '{-3, 4, 0, 0, 10, 0}, known: 1, ans: '{1280, REG_START}}; rows.push_back(r);
    r = '{q: '{0, 4, 0, 0, 10, 0}, known: 1, ans: '{1024, REG_START}}; rows.push_back(r);
    r = '{q: '{13, 4, 0, 0, 10, 0}, known: 1, ans: '{1280, REG_END}}; rows.push_back(r);
    r = '{q: '{10, 4, 0, 0, 10, 0}, known: 1, ans: '{1024, REG_END}}; rows.push_back(r);
    r = '{q: '{5, 7, 0, 0, 10, 0}, known: 1, ans: '{1792, REG_INTERIOR}}; rows.push_back(r);
    r = '{q: '{5, -7, 0, 0, 10, 0}, known: 1, ans: '{1792, REG_INTERIOR}}; rows.push_back(r);
    r = '{q: '{1, 0, 0, 0, 1, 1}, known: 0, ans: none}; rows.push_back(r);
    r = '{q: '{32767, 32767, -32768, -32768, -32768, -32768}, known: 0, ans: none};
    rows.push_back(r);
    r = '{q: '{-32768, 32767, 32767, -32768, -32768, -32768}, known: 0, ans: none};
    rows.push_back(r);
    r = '{q: '{32767, -32768, -32768, 32767, 32767, -32768}, known: 0, ans: none};
    rows.push_back(r);
    r = '{q: '{0, 32767, -32768, -32768, 32767, -32768}, known: 0, ans: none};
    rows.push_back(r);
    r = '{q: '{0, -32768, -32768, 32767, 32767, 32767}, known: 0, ans: none};
    rows.push_back(r);
    r = '{q: '{-1, -1, -1, -1, -1, -1}, known: 0, ans: none}; rows.push_back(r);
    r = '{q: '{1, 1, 0, 0, 3, 3}, known: 0, ans: none}; rows.push_back(r);
    r = '{q: '{2, 1, 0, 0, 3, 1}, known: 0, ans: none}; rows.push_back(r);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_query(rows[i].q, rows[i].known, rows[i].ans);
    in_tvalid <= 1'b0;

    // Hold off until the pipeline has drained once.
    while (pending_answers.size() != 0) @(posedge clk);

    // Random queries: mostly small coordinates so all regions show up, some full range.
    for (int n = 0; n < 900; n++) begin
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 20;
        2: span = 1000;
        default: span = 30000;
      endcase
      q.px = rand_coord(span); q.py = rand_coord(span);
      q.ax = rand_coord(span); q.ay = rand_coord(span);
      if ($urandom_range(0, 19) == 0) begin
        q.bx = q.ax; q.by = q.ay;
      end else begin
        q.bx = rand_coord(span); q.by = rand_coord(span);
      end
      send_query(q, 1'b0, none);
      if (n == 450) begin
        in_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d queries, checked %0d results.", sent, received);
    $display("Regions seen: interior %0d, start %0d, end %0d.",
             region_hits[0], region_hits[1], region_hits[2]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
